// ----- sv/btr_pkg.sv -----
// Package for the bitmap text row renderer: request codes, widths and shared types.
// No dependencies.
`default_nettype none
package btr_pkg;

  localparam logic [1:0] REQ_LOAD_ROW   = 2'd0;
  localparam logic [1:0] REQ_LOAD_WIDTH = 2'd1;
  localparam logic [1:0] REQ_START      = 2'd2;
  localparam logic [1:0] REQ_DRAW       = 2'd3;

  localparam logic [2:0] CFG_INK       = 3'd0;
  localparam logic [2:0] CFG_NO_ALPHA  = 3'd1;
  localparam logic [2:0] CFG_IMG_W     = 3'd2;
  localparam logic [2:0] CFG_IMG_H     = 3'd3;
  localparam logic [2:0] CFG_SCALE     = 3'd4;
  localparam logic [2:0] CFG_LINE_H    = 3'd5;

  localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_CTRL_MAX = 8'h1F;

  localparam logic [31:0] RGB_MASK   = 32'h00FF_FFFF;
  localparam logic [31:0] ALPHA_MASK = 32'hFF00_0000;

  localparam logic [23:0] PEN_MAX = 24'hFF_FFFF;
  localparam logic signed [19:0] TOP_MAX = 20'sd524287;
  localparam logic [12:0] IMG_MAX = 13'd4096;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FETCH = 7'b0000010,
    ST_MASK  = 7'b0000100,
    ST_CLIP  = 7'b0001000,
    ST_EMIT  = 7'b0010000,
    ST_ADV   = 7'b0100000,
    ST_SUM   = 7'b1000000
  } state_e;

endpackage
`default_nettype wire

// ----- sv/btr_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module btr_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ----- sv/bitmap_text_row_renderer.sv -----
// Top level of the bitmap text row renderer: config registers, sequencer, pen state.
// Depends on btr_pkg and btr_ram.
//
//  channel | direction | handshake            | payload
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index_i, cfg_data_i
//  req     | in        | in_valid/in_ready    | req_type_i .. snap_to_scale_i
//  res     | out       | out_valid/out_ready  | is_row_o .. last_o
//
// Loads and starts are done as the request is accepted. For a printable code a draw
// reads, expands and clips each glyph row and, for a row with pixels in view, steps
// once per scaled row (also when that scaled row falls outside the image vertically),
// then advances the pen and sends the summary; other control codes go straight to the
// advance, a newline to the summary. A stalled result holds the sequencer. Reset clears
// pen state and control registers, not the output payload or the glyph and width RAMs.
`default_nettype none
module bitmap_text_row_renderer #(
  parameter int MAX_SCALE  = 4,
  parameter int GLYPH_ROWS = 8,
  parameter int CHAR_COUNT = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [2:0]  row_index_i,
  input  wire logic [7:0]  glyph_bits_i,
  input  wire logic [7:0]  advance_width_i,
  input  wire logic signed [15:0] origin_x_i,
  input  wire logic signed [15:0] origin_y_i,
  input  wire logic [15:0] space_extra_i,
  input  wire logic        snap_to_scale_i,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             is_row_o,
  output logic [11:0]      row_y_o,
  output logic signed [17:0] span_x_o,
  output logic [31:0]      pixel_mask_o,
  output logic [31:0]      pixel_color_o,
  output logic [15:0]      text_width_o,
  output logic             last_o
);
  localparam int CodeW  = $clog2(CHAR_COUNT);
  localparam int RowW   = $clog2(GLYPH_ROWS);
  localparam int ScaleCap = (MAX_SCALE < 4) ? MAX_SCALE : 4;

  // configuration registers
  logic [31:0] ink_q;
  logic        no_alpha_q;
  logic [12:0] img_w_q, img_h_q;
  logic [2:0]  scale_cfg_q;
  logic [3:0]  line_h_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ink_q       <= '0;
      no_alpha_q  <= 1'b1;
      img_w_q     <= 13'd640;
      img_h_q     <= 13'd480;
      scale_cfg_q <= 3'd1;
      line_h_q    <= 4'd8;
    end else if (cfg_valid) begin
      case (cfg_index_i)
        btr_pkg::CFG_INK:      ink_q       <= cfg_data_i;
        btr_pkg::CFG_NO_ALPHA: no_alpha_q  <= cfg_data_i[0];
        btr_pkg::CFG_IMG_W:    img_w_q     <= cfg_data_i[12:0];
        btr_pkg::CFG_IMG_H:    img_h_q     <= cfg_data_i[12:0];
        btr_pkg::CFG_SCALE:    scale_cfg_q <= cfg_data_i[2:0];
        btr_pkg::CFG_LINE_H:   line_h_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // effective scale, width and height
  logic [2:0] sc;
  logic [12:0] img_w, img_h;
  always_comb begin
    sc = scale_cfg_q;
    if (sc == 3'd0) sc = 3'd1;
    if (sc > 3'(ScaleCap)) sc = 3'(ScaleCap);
    img_w = (img_w_q > btr_pkg::IMG_MAX) ? btr_pkg::IMG_MAX : img_w_q;
    img_h = (img_h_q > btr_pkg::IMG_MAX) ? btr_pkg::IMG_MAX : img_h_q;
  end

  btr_pkg::state_e state_q, state_d;
  logic in_acc;
  assign in_ready = (state_q == btr_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  logic [7:0]  code_q;
  logic        code_ok;
  assign code_ok = ({1'b0, code_q} < 9'(CHAR_COUNT));

  // glyph and width memories
  logic [RowW-1:0] row_q;
  logic [7:0] glyph_rd, width_rd;
  logic g_we, w_we;
  logic [7:0] wcode;
  assign g_we = in_acc && req_type_i == btr_pkg::REQ_LOAD_ROW
                && {1'b0, char_code_i} < 9'(CHAR_COUNT);
  assign w_we = in_acc && req_type_i == btr_pkg::REQ_LOAD_WIDTH
                && {1'b0, char_code_i} < 9'(CHAR_COUNT);
  // width is read at the accepting edge so a control code can advance right away
  assign wcode = in_ready ? char_code_i : code_q;

  btr_ram #(.Width(8), .Depth(CHAR_COUNT * GLYPH_ROWS)) u_glyph (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i ({char_code_i[CodeW-1:0], row_index_i[RowW-1:0]}),
    .wdata_i (glyph_bits_i),
    .raddr_i ({code_q[CodeW-1:0], row_q}),
    .rdata_o (glyph_rd)
  );

  btr_ram #(.Width(8), .Depth(CHAR_COUNT)) u_width (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (char_code_i[CodeW-1:0]),
    .wdata_i (advance_width_i),
    .raddr_i (wcode[CodeW-1:0]),
    .rdata_o (width_rd)
  );

  // pen state
  logic [23:0] pen_off_q, pen_off_d;
  logic signed [15:0] pen_left_q;
  logic signed [19:0] pen_top_q, pen_top_d;
  logic [15:0] bonus_q;
  logic        snap_q;
  logic [15:0] widest_q, widest_d;

  // per-draw working registers
  logic signed [20:0] xstart_q;
  logic [31:0] mask_q, mask_d;
  logic [2:0]  sub_q, sub_d;
  logic [2:0]  row_d;
  logic        gap_q;

  // x start: integer pen with optional snap down to a multiple of the scale
  logic [19:0] pint, pint_snap;
  logic [1:0]  prem;
  logic [4:0]  m3_a;
  logic [2:0]  m3_b;
  always_comb begin
    pint = pen_off_q[23:4];
    // remainder by 3: 4 is 1 mod 3, so sum base-4 digits and fold once more
    m3_a = '0;
    for (int d = 0; d < 10; d++) m3_a = m3_a + 5'(pint[2*d +: 2]);
    m3_b = 3'(m3_a[1:0]) + 3'(m3_a[3:2]) + 3'(m3_a[4]);
    case (sc)
      3'd2: prem = {1'b0, pint[0]};
      3'd3: prem = (m3_b >= 3'd6) ? 2'(m3_b - 3'd6)
                 : ((m3_b >= 3'd3) ? 2'(m3_b - 3'd3) : m3_b[1:0]);
      3'd4: prem = pint[1:0];
      default: prem = 2'd0;
    endcase
    pint_snap = snap_q ? pint - 20'(prem) : pint;
  end

  // mask expansion of one glyph row
  logic [31:0] exp_mask;
  always_comb begin
    exp_mask = '0;
    for (int c = 0; c < 8; c++) begin
      for (int j = 0; j < 4; j++) begin
        if (glyph_rd[c] && code_ok && 3'(j) < sc) exp_mask[c * 32'(sc) + j] = 1'b1;
      end
    end
  end

  // horizontal clip of the held mask
  logic [31:0] clip_mask;
  always_comb begin
    logic signed [21:0] xt;
    clip_mask = mask_q;
    for (int k = 0; k < 32; k++) begin
      xt = 22'(xstart_q) + 22'(k);
      if (xt < 0 || xt >= $signed({9'd0, img_w})) clip_mask[k] = 1'b0;
    end
  end

  // current output row
  logic signed [20:0] yt;
  logic y_vis;
  assign yt = 21'(pen_top_q) + 21'(row_q * sc) + 21'(sub_q);
  assign y_vis = (yt >= 0) && (yt < $signed({8'd0, img_h}));

  // pen advance (shared arithmetic)
  logic [24:0] adv_sum;
  logic [23:0] pen_sat;
  logic [23:0] ext_raw;
  logic [15:0] ext;
  always_comb begin
    adv_sum = 25'(pen_off_q) + 25'({width_rd, 4'd0} * sc)
            + ((code_q == btr_pkg::CHAR_SPACE) ? 25'(bonus_q) : 25'd0);
    if (!code_ok) adv_sum = 25'(pen_off_q);
    pen_sat = adv_sum[24] ? btr_pkg::PEN_MAX : adv_sum[23:0];
    ext_raw = (pen_sat > 24'({sc, 4'd0})) ? (pen_sat - 24'({sc, 4'd0})) >> 4 : 24'd0;
    ext = (ext_raw > 24'd65535) ? 16'hFFFF : ext_raw[15:0];
  end

  // output register
  logic        ov_q, ov_d;
  logic        is_row_q, is_row_d;
  logic [11:0] ry_q, ry_d;
  logic signed [17:0] sx_q, sx_d;
  logic [31:0] om_q, om_d, oc_q, oc_d;
  logic [15:0] tw_q, tw_d;
  logic        last_q, last_d;
  logic [31:0] color;
  assign color = no_alpha_q ? (ink_q & btr_pkg::RGB_MASK) : (ink_q | btr_pkg::ALPHA_MASK);
  logic out_free;
  assign out_free = !ov_q || out_ready;

  logic signed [20:0] top_sum;
  assign top_sum = 21'(pen_top_q) + 21'(line_h_q * sc);

  // sequencer
  always_comb begin
    state_d = state_q; row_d = row_q; sub_d = sub_q; mask_d = mask_q;
    pen_off_d = pen_off_q; pen_top_d = pen_top_q; widest_d = widest_q;
    ov_d = ov_q && !out_ready; is_row_d = is_row_q; ry_d = ry_q; sx_d = sx_q;
    om_d = om_q; oc_d = oc_q; tw_d = tw_q; last_d = last_q;
    case (state_q)
      btr_pkg::ST_IDLE: begin
        if (in_acc && req_type_i == btr_pkg::REQ_START) begin
          pen_off_d = '0; widest_d = '0; pen_top_d = 20'(origin_y_i);
        end else if (in_acc && req_type_i == btr_pkg::REQ_DRAW) begin
          row_d = '0;
          if (char_code_i == btr_pkg::CHAR_NEWLINE) begin
            pen_off_d = '0;
            pen_top_d = (top_sum > 21'(btr_pkg::TOP_MAX)) ? btr_pkg::TOP_MAX : top_sum[19:0];
            state_d = btr_pkg::ST_SUM;
          end else if (char_code_i > btr_pkg::CHAR_CTRL_MAX) begin
            state_d = btr_pkg::ST_FETCH;
          end else begin
            state_d = btr_pkg::ST_ADV;
          end
        end
      end
      btr_pkg::ST_FETCH: state_d = btr_pkg::ST_MASK;
      btr_pkg::ST_MASK: begin
        mask_d = exp_mask; state_d = btr_pkg::ST_CLIP;
      end
      btr_pkg::ST_CLIP: begin
        mask_d = clip_mask; sub_d = '0;
        if (clip_mask == '0) begin
          if (row_q == RowW'(GLYPH_ROWS - 1)) state_d = btr_pkg::ST_ADV;
          else begin row_d = row_q + 1'b1; state_d = btr_pkg::ST_FETCH; end
        end else state_d = btr_pkg::ST_EMIT;
      end
      btr_pkg::ST_EMIT: begin
        if (!y_vis || out_free) begin
          if (y_vis) begin
            ov_d = 1'b1; is_row_d = 1'b1; ry_d = yt[11:0]; sx_d = xstart_q[17:0];
            om_d = mask_q; oc_d = color; tw_d = '0; last_d = 1'b0;
          end
          if (sub_q == sc - 3'd1) begin
            if (row_q == RowW'(GLYPH_ROWS - 1)) state_d = btr_pkg::ST_ADV;
            else begin row_d = row_q + 1'b1; state_d = btr_pkg::ST_FETCH; end
          end else sub_d = sub_q + 3'd1;
        end
      end
      btr_pkg::ST_ADV: begin
        pen_off_d = pen_sat;
        if (ext > widest_q) widest_d = ext;
        state_d = btr_pkg::ST_SUM;
      end
      btr_pkg::ST_SUM: begin
        if (out_free) begin
          ov_d = 1'b1; is_row_d = 1'b0; ry_d = '0; sx_d = '0; om_d = '0; oc_d = '0;
          tw_d = widest_q; last_d = 1'b1; state_d = btr_pkg::ST_IDLE;
        end
      end
      default: state_d = btr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btr_pkg::ST_IDLE; pen_off_q <= '0; pen_left_q <= '0; pen_top_q <= '0;
      bonus_q <= '0; snap_q <= 1'b0; widest_q <= '0; ov_q <= 1'b0;
      row_q <= '0; sub_q <= '0; code_q <= '0; gap_q <= 1'b0;
    end else begin
      state_q <= state_d; pen_off_q <= pen_off_d; pen_top_q <= pen_top_d;
      widest_q <= widest_d; ov_q <= ov_d; row_q <= row_d; sub_q <= sub_d;
      gap_q <= 1'b0;
      if (in_acc) code_q <= char_code_i;
      if (in_acc && req_type_i == btr_pkg::REQ_START) begin
        pen_left_q <= origin_x_i;
        bonus_q <= space_extra_i; snap_q <= snap_to_scale_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d; is_row_q <= is_row_d; ry_q <= ry_d; sx_q <= sx_d;
    om_q <= om_d; oc_q <= oc_d; tw_q <= tw_d; last_q <= last_d;
    if (state_q == btr_pkg::ST_FETCH) xstart_q <= 21'(pen_left_q) + 21'(pint_snap);
  end

  assign out_valid     = ov_q && !gap_q;
  assign is_row_o      = is_row_q;
  assign row_y_o       = ry_q;
  assign span_x_o      = sx_q;
  assign pixel_mask_o  = om_q;
  assign pixel_color_o = oc_q;
  assign text_width_o  = tw_q;
  assign last_o        = last_q;
endmodule
`default_nettype wire

// ----- sv/btr_checker.sv -----
// Port-level checker for the bitmap text row renderer, bound to the top level.
// Depends on bitmap_text_row_renderer ports only.
`default_nettype none
module btr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        is_row_o,
  input wire logic [31:0] pixel_mask_o,
  input wire logic [15:0] text_width_o,
  input wire logic        last_o
);
  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(pixel_mask_o) && $stable(last_o))
    else $error("result changed while stalled");
  // row writes never carry an empty mask
  a_row_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && is_row_o |-> pixel_mask_o != 32'd0)
    else $error("empty row mask");
  // last marks exactly the summary
  a_last_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (last_o == !is_row_o))
    else $error("last does not match summary");
  // row writes carry no width
  a_row_tw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && is_row_o |-> text_width_o == 16'd0)
    else $error("row write with width");
  // a waiting result survives the accept of a new item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
endmodule

bind bitmap_text_row_renderer btr_checker u_btr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .is_row_o(is_row_o),
  .pixel_mask_o(pixel_mask_o), .text_width_o(text_width_o), .last_o(last_o)
);
`default_nettype wire

// ----- bench/tb_bitmap_text_row_renderer.sv -----
// Self-checking bench for bitmap_text_row_renderer: font loads, text starts, glyph draws.
// Depends on btr_pkg and the renderer RTL; predicts every row write and summary internally.
`default_nettype none
module tb_bitmap_text_row_renderer;

  localparam int SETTLE_CYCLES = 64;    // longest draw with no visible row, plus margin
  localparam int STALL_LIMIT   = 2000;  // cycles with no item moved on any channel

  typedef struct {
    logic [1:0]         kind;
    logic [7:0]         code;
    logic [2:0]         row;
    logic [7:0]         bits;
    logic [7:0]         adv;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic [15:0]        extra;
    logic               snap;
  } text_req_t;

  typedef struct {
    logic        is_row;
    logic [11:0] y;
    logic [17:0] x;
    logic [31:0] mask;
    logic [31:0] color;
    logic [15:0] tw;
    logic        last;
  } row_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] req_type_i = '0;
  logic [7:0] char_code_i = '0;
  logic [2:0] row_index_i = '0;
  logic [7:0] glyph_bits_i = '0;
  logic [7:0] advance_width_i = '0;
  logic signed [15:0] origin_x_i = '0;
  logic signed [15:0] origin_y_i = '0;
  logic [15:0] space_extra_i = '0;
  logic snap_to_scale_i = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic is_row_o;
  logic [11:0] row_y_o;
  logic signed [17:0] span_x_o;
  logic [31:0] pixel_mask_o;
  logic [31:0] pixel_color_o;
  logic [15:0] text_width_o;
  logic last_o;

  bitmap_text_row_renderer DUT (.*);

  always #6 clk_i = ~clk_i;

  // Predicted font, pen and register copies
  logic [7:0] font_rows [0:2047];
  logic [7:0] font_adv [0:255];
  logic [7:0] rows_loaded [0:255];
  bit width_loaded [0:255];
  int unsigned pen_q4, space_q4, widest;
  int left_x, top_y;
  bit snap_on;
  logic [31:0] ink = '0;
  bit no_alpha = 1'b1;
  int unsigned img_w = 640, img_h = 480, scale = 1, line_h = 8;

  row_res_t pending_writes[$];
  bit failed = 1'b0;
  bit quiet = 1'b0;        // no random gaps on either side
  int hold_len = 0;        // one long receiver hold-off

  // Expected results of one accepted item
  task automatic render_model(input text_req_t r);
    int unsigned sc, pint, ext, wcap, hcap;
    longint xs, xt, yt;
    logic [31:0] m, color;
    logic [7:0] g;
    row_res_t e;
    case (r.kind)
      btr_pkg::REQ_LOAD_ROW: begin
        font_rows[{r.code, r.row}] = r.bits;
        rows_loaded[r.code][r.row] = 1'b1;
      end
      btr_pkg::REQ_LOAD_WIDTH: begin
        font_adv[r.code] = r.adv;
        width_loaded[r.code] = 1'b1;
      end
      btr_pkg::REQ_START: begin
        left_x = r.ox;
        top_y = r.oy;
        space_q4 = r.extra;
        snap_on = r.snap;
        pen_q4 = 0;
        widest = 0;
      end
      default: begin
        sc = (scale == 0) ? 1 : (scale > 4 ? 4 : scale);
        wcap = (img_w > 4096) ? 4096 : img_w;
        hcap = (img_h > 4096) ? 4096 : img_h;
        e = '{default: '0};
        e.last = 1'b1;
        if (r.code == btr_pkg::CHAR_NEWLINE) begin
          top_y = top_y + int'(line_h * sc);
          if (top_y > 524287) top_y = 524287;
          pen_q4 = 0;
          e.tw = widest[15:0];
          pending_writes.push_back(e);
        end else begin
          if (r.code > btr_pkg::CHAR_CTRL_MAX) begin
            color = no_alpha ? (ink & btr_pkg::RGB_MASK) : (ink | btr_pkg::ALPHA_MASK);
            pint = pen_q4 >> 4;
            if (snap_on) pint = pint - pint % sc;
            xs = longint'(left_x) + longint'(pint);
            for (int gr = 0; gr < 8; gr++) begin
              g = font_rows[{r.code, 3'(gr)}];
              m = '0;
              for (int c = 0; c < 8; c++)
                for (int j = 0; j < sc; j++) m[c * sc + j] = g[c];
              for (int k = 0; k < 8 * sc; k++) begin
                xt = xs + k;
                if (xt < 0 || xt >= longint'(wcap)) m[k] = 1'b0;
              end
              if (m == '0) continue;
              for (int j = 0; j < sc; j++) begin
                yt = longint'(top_y) + gr * sc + j;
                if (yt < 0 || yt >= longint'(hcap)) continue;
                pending_writes.push_back('{1'b1, yt[11:0], xs[17:0], m, color, 16'h0, 1'b0});
              end
            end
          end
          pen_q4 += font_adv[r.code] * sc * 16;
          if (r.code == btr_pkg::CHAR_SPACE) pen_q4 += space_q4;
          if (pen_q4 > btr_pkg::PEN_MAX) pen_q4 = btr_pkg::PEN_MAX;
          ext = pen_q4 > sc * 16 ? (pen_q4 - sc * 16) >> 4 : 0;
          if (ext > 65535) ext = 65535;
          if (ext > widest) widest = ext;
          e.tw = widest[15:0];
          pending_writes.push_back(e);
        end
      end
    endcase
  endtask

  function automatic text_req_t any_req(input logic [1:0] kind, input logic [7:0] code);
    text_req_t r;
    r.kind = kind;
    r.code = code;
    r.row = 3'($urandom);
    r.bits = 8'($urandom);
    r.adv = 8'($urandom);
    r.ox = 16'($urandom);
    r.oy = 16'($urandom);
    r.extra = 16'($urandom);
    r.snap = 1'($urandom);
    return r;
  endfunction

  // Drawing a code must never read a font entry that was never loaded
  function automatic bit can_draw(input logic [7:0] code);
    if (code == btr_pkg::CHAR_NEWLINE) return 1'b1;
    if (!width_loaded[code]) return 1'b0;
    return code <= btr_pkg::CHAR_CTRL_MAX || rows_loaded[code] == 8'hFF;
  endfunction

  task automatic send_req(input text_req_t r);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_type_i <= r.kind;
    char_code_i <= r.code;
    row_index_i <= r.row;
    glyph_bits_i <= r.bits;
    advance_width_i <= r.adv;
    origin_x_i <= r.ox;
    origin_y_i <= r.oy;
    space_extra_i <= r.extra;
    snap_to_scale_i <= r.snap;
    do @(posedge clk_i); while (!in_ready);
    render_model(r);
  endtask

  task automatic draw(input logic [7:0] code);
    send_req(any_req(btr_pkg::REQ_DRAW, code));
  endtask

  task automatic start_text(input int ox, input int oy, input int extra, input bit snap);
    text_req_t r;
    r = any_req(btr_pkg::REQ_START, 8'($urandom));
    r.ox = 16'(ox);
    r.oy = 16'(oy);
    r.extra = 16'(extra);
    r.snap = snap;
    send_req(r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      btr_pkg::CFG_INK:      ink = val;
      btr_pkg::CFG_NO_ALPHA: no_alpha = val[0];
      btr_pkg::CFG_IMG_W:    img_w = val[12:0];
      btr_pkg::CFG_IMG_H:    img_h = val[12:0];
      btr_pkg::CFG_SCALE:    scale = val[2:0];
      btr_pkg::CFG_LINE_H:   line_h = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_style(input int sc, input bit na, input int w, input int h,
                           input int lh, input logic [31:0] color);
    write_reg(btr_pkg::CFG_SCALE, sc);
    write_reg(btr_pkg::CFG_NO_ALPHA, na);
    write_reg(btr_pkg::CFG_IMG_W, w);
    write_reg(btr_pkg::CFG_IMG_H, h);
    write_reg(btr_pkg::CFG_LINE_H, lh);
    write_reg(btr_pkg::CFG_INK, color);
  endtask

  // Small font: space, two glyphs, a full block, two control widths
  task automatic test_font_load();
    logic [7:0] glyphs [4] = '{btr_pkg::CHAR_SPACE, 8'h41, 8'h80, 8'hFF};
    text_req_t r;
    foreach (glyphs[i]) begin
      for (int row = 0; row < 8; row++) begin
        r = any_req(btr_pkg::REQ_LOAD_ROW, glyphs[i]);
        r.row = 3'(row);
        if (glyphs[i] == 8'hFF) r.bits = 8'hFF;
        else if (glyphs[i] == btr_pkg::CHAR_SPACE) r.bits = 8'h00;
        else if (row == 0) r.bits = 8'h81;
        send_req(r);
      end
      r = any_req(btr_pkg::REQ_LOAD_WIDTH, glyphs[i]);
      r.adv = glyphs[i] == 8'hFF ? 8'd255 : (glyphs[i] == 8'h80 ? 8'd0 : 8'd6);
      send_req(r);
    end
    r = any_req(btr_pkg::REQ_LOAD_WIDTH, 8'h00);
    r.adv = 8'd5;
    send_req(r);
    r = any_req(btr_pkg::REQ_LOAD_WIDTH, btr_pkg::CHAR_CTRL_MAX);
    r.adv = 8'd2;
    send_req(r);
    wait_drained();
  endtask

  // Plain text, spaces, control codes, newline, clipping at the edges
  task automatic test_directed_draw();
    start_text(0, 0, 16'h0018, 1'b0);
    draw(8'h41); draw(btr_pkg::CHAR_SPACE); draw(8'h00); draw(btr_pkg::CHAR_CTRL_MAX);
    draw(btr_pkg::CHAR_NEWLINE); draw(8'hFF); draw(8'h80);
    write_reg(btr_pkg::CFG_SCALE, 3);
    start_text(-4, -3, 16'h0007, 1'b1);
    draw(8'h41); draw(btr_pkg::CHAR_SPACE); draw(8'h41); draw(8'hFF);
    start_text(32767, 32767, 0, 1'b0);
    draw(8'h41);
    start_text(-32768, -32768, 16'hFFFF, 1'b1);
    draw(8'h41); draw(btr_pkg::CHAR_SPACE); draw(btr_pkg::CHAR_NEWLINE);
    start_text(636, 475, 0, 1'b0);
    draw(8'hFF);
    wait_drained();
  endtask

  task automatic test_config_sweep();
    set_style(1, 1'b1, 4096, 4096, 1, 32'h0);
    start_text(4090, 4090, 16'h0020, 1'b0);
    draw(8'hFF); draw(btr_pkg::CHAR_NEWLINE); draw(8'h41);
    set_style(4, 1'b0, 1, 1, 8, 32'hFFFF_FFFF);
    start_text(0, 0, 0, 1'b1);
    draw(8'hFF); draw(btr_pkg::CHAR_SPACE); draw(btr_pkg::CHAR_NEWLINE);
    set_style(2, 1'b0, 33, 17, 3, $urandom);
    start_text(-2, 1, 16'h0011, 1'b1);
    draw(8'h41); draw(btr_pkg::CHAR_SPACE); draw(8'hFF); draw(btr_pkg::CHAR_NEWLINE);
    draw(8'h41);
    wait_drained();
  endtask

  // Results held back while the sender keeps going, then a full drain
  task automatic test_backpressure();
    set_style(4, 1'b1, 640, 480, 8, $urandom);
    hold_len = 400;
    quiet = 1'b1;
    start_text(0, 0, 0, 1'b0);
    repeat (10) draw(8'hFF);
    quiet = 1'b0;
    wait_drained();
  endtask

  // Wide spaces push the measured width into its clamp; a few newlines from far down
  task automatic test_pen_limits();
    quiet = 1'b1;
    start_text(0, 0, 16'hFFFF, 1'b0);
    repeat (18) draw(btr_pkg::CHAR_SPACE);
    draw(8'hFF);
    start_text(0, 32767, 0, 1'b0);
    repeat (3) draw(btr_pkg::CHAR_NEWLINE);
    draw(8'h41); draw(btr_pkg::CHAR_NEWLINE);
    quiet = 1'b0;
    wait_drained();
  endtask

  task automatic test_random();
    text_req_t r;
    int p;
    for (int phase = 0; phase < 2; phase++) begin
      set_style($urandom_range(1, 4), 1'($urandom), $urandom_range(1, 4) == 1 ?
                $urandom_range(1, 4096) : $urandom_range(16, 300),
                $urandom_range(1, 4) == 1 ? $urandom_range(1, 4096) : $urandom_range(16, 200),
                $urandom_range(1, 8), $urandom);
      start_text(0, 0, $urandom_range(0, 64), 1'($urandom));
      repeat (9) begin
        p = $urandom_range(0, 99);
        if (p < 8) begin
          r = any_req(btr_pkg::REQ_LOAD_ROW, 8'($urandom));
        end else if (p < 12) begin
          r = any_req(btr_pkg::REQ_LOAD_WIDTH, 8'($urandom));
          r.adv = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 12));
        end else if (p < 22) begin
          r = any_req(btr_pkg::REQ_START, 8'($urandom));
          if ($urandom_range(0, 3) != 0) begin
            r.ox = 16'(int'($urandom_range(0, 216)) - 16);
            r.oy = 16'(int'($urandom_range(0, 216)) - 16);
            r.extra = 16'($urandom_range(0, 255));
          end
        end else begin
          r = any_req(btr_pkg::REQ_DRAW, btr_pkg::CHAR_NEWLINE);
          if ($urandom_range(0, 9) != 0)
            do r.code = 8'($urandom); while (!can_draw(r.code));
        end
        send_req(r);
      end
    end
    wait_drained();
  endtask

  // Receiver: random stalls, one long hold-off, in-order field checks
  initial begin
    row_res_t e;
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end
      stall = quiet ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      if (pending_writes.size() == 0) begin
        $error("unexpected result: is_row %0b last %0b", is_row_o, last_o);
        failed = 1'b1;
      end else begin
        e = pending_writes.pop_front();
        if (is_row_o !== e.is_row) begin
          $error("is_row expected %0h actual %0h", e.is_row, is_row_o); failed = 1'b1;
        end
        if (row_y_o !== e.y) begin
          $error("row_y expected %0h actual %0h", e.y, row_y_o); failed = 1'b1;
        end
        if (span_x_o !== e.x) begin
          $error("span_x expected %0h actual %0h", e.x, span_x_o); failed = 1'b1;
        end
        if (pixel_mask_o !== e.mask) begin
          $error("pixel_mask expected %0h actual %0h", e.mask, pixel_mask_o); failed = 1'b1;
        end
        if (pixel_color_o !== e.color) begin
          $error("pixel_color expected %0h actual %0h", e.color, pixel_color_o); failed = 1'b1;
        end
        if (text_width_o !== e.tw) begin
          $error("text_width expected %0h actual %0h", e.tw, text_width_o); failed = 1'b1;
        end
        if (last_o !== e.last) begin
          $error("last expected %0h actual %0h", e.last, last_o); failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: ends the run when no channel moves an item for too long
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    foreach (rows_loaded[i]) begin
      rows_loaded[i] = '0;
      width_loaded[i] = 1'b0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_font_load();
    test_directed_draw();
    test_config_sweep();
    test_backpressure();
    test_pen_limits();
    test_random();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_writes.size() != 0) begin
      $error("%0d expected results never arrived", pending_writes.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- bitmap_text_row_renderer.f -----
sv/btr_pkg.sv
sv/btr_ram.sv
sv/bitmap_text_row_renderer.sv
sv/btr_checker.sv
bench/tb_bitmap_text_row_renderer.sv
